@@ rtl/mkd_pkg.sv @@
// Shared constants and types for the matrix keypad debounce block.
`timescale 1ns / 1ps
package mkd_pkg;

	// Matrix geometry
	localparam int COLUMNS   = 4;
	localparam int ROWS      = 4;
	localparam int KEY_COUNT = COLUMNS * ROWS;

	// Field widths
	localparam int LEVEL_W = 16;
	localparam int CODE_W  = 5;
	localparam int COUNT_W = 8;

	// Only row bits that exist in both the matrix and the level word are scanned.
	localparam int SCAN_BITS = (KEY_COUNT < LEVEL_W) ? KEY_COUNT : LEVEL_W;

	// Reset value of the settle tick register
	localparam logic [COUNT_W-1:0] SETTLE_RESET = COUNT_W'(5);

	// Function codes of an input item
	typedef enum logic {
		FUNC_SCAN = 1'b0,
		FUNC_READ = 1'b1
	} func_t;

	// Item handed from the input register to the debounce state
	typedef struct packed {
		logic               valid;
		func_t              func;
		logic [CODE_W-1:0]  raw;
	} item_t;

endpackage

@@ rtl/matrix_keypad_debounce.sv @@
// Top level of the debounced 4x4 key matrix scanner.
`timescale 1ns / 1ps
// Usage:
// Input channel (in_valid, in_stall, func, row_levels) takes one item per transfer:
// a scan tick carrying the row levels of every driven column, or a read that
// returns and clears the latched press event. The output channel (out_valid,
// out_stall, event_key, stable_key, raw_code) gives exactly one result per item.
// An item that is transferred in goes first into the input register and then into the
// result register, from which it is transferred out.
// Throughput is one item per cycle while the receiver does not stall; the debounce
// state is updated as an item moves from the input register to the result register.
// When the receiver stalls, the result register holds its value and the input
// register can still take one more item; in_stall rises only when both are full.
// The settle tick register is written over cfg_valid/cfg_ready/cfg_data, which
// is always ready; write it only while the block is idle.
// Reset clears both registers, all debounce state and the press event, and sets
// the settle tick count to five.
module matrix_keypad_debounce (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [mkd_pkg::LEVEL_W-1:0] row_levels,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mkd_pkg::CODE_W-1:0]  event_key,
	output logic [mkd_pkg::CODE_W-1:0]  stable_key,
	output logic [mkd_pkg::CODE_W-1:0]  raw_code,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mkd_pkg::COUNT_W-1:0] cfg_data
);

	logic                        valid_s1;
	mkd_pkg::func_t              func_s1;
	logic [mkd_pkg::LEVEL_W-1:0] levels_s1;
	logic                        valid_s2;
	logic [mkd_pkg::CODE_W-1:0]  event_s2, stable_s2, raw_s2;
	logic [mkd_pkg::COUNT_W-1:0] settle_q;
	logic [mkd_pkg::CODE_W-1:0]  enc_code;
	logic [mkd_pkg::CODE_W-1:0]  core_event, core_stable;
	logic                        advance;
	mkd_pkg::item_t              item;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= mkd_pkg::SETTLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			settle_q <= cfg_data;
		end
	end

	// Handshake: the input register moves on when the result register is free.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1   <= mkd_pkg::func_t'(func);
			levels_s1 <= row_levels;
		end
	end

	// Key encoding and debounce
	mkd_encoder u_encoder (
		.levels (levels_s1),
		.code   (enc_code)
	);

	always_comb begin
		item.valid = valid_s1;
		item.func  = func_s1;
		item.raw   = (func_s1 == mkd_pkg::FUNC_SCAN) ? enc_code : '0;
	end

	mkd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item),
		.settle_ticks (settle_q),
		.event_key    (core_event),
		.stable_key   (core_stable)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2  <= core_event;
			stable_s2 <= core_stable;
			raw_s2    <= item.raw;
		end
	end

	assign out_valid  = valid_s2;
	assign event_key  = event_s2;
	assign stable_key = stable_s2;
	assign raw_code   = raw_s2;

	// A scan result never carries a press event.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && raw_s2 != '0 |-> event_s2 == '0)
		else $error("press event reported on a scan result");

	// Key codes stay within the matrix.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> stable_s2 <= mkd_pkg::CODE_W'(mkd_pkg::KEY_COUNT) &&
			raw_s2 <= mkd_pkg::CODE_W'(mkd_pkg::KEY_COUNT))
		else $error("key code beyond the matrix");

	// Input is held off only when both registers are occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with a free register");

	// A read followed directly by another read finds no event.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && func_s1 == mkd_pkg::FUNC_READ ##1
		advance && func_s1 == mkd_pkg::FUNC_READ |-> core_event == '0)
		else $error("press event not cleared by a read");

endmodule

@@ rtl/mkd_encoder.sv @@
// Priority encoder turning sampled row levels into a raw key code.
`timescale 1ns / 1ps
module mkd_encoder (
	input  logic [mkd_pkg::LEVEL_W-1:0] levels,
	output logic [mkd_pkg::CODE_W-1:0]  code
);

	// Lowest set bit wins: walk from the top so that lower bits overwrite.
	always_comb begin
		code = '0;
		for (int i = mkd_pkg::SCAN_BITS - 1; i >= 0; i--) begin
			if (levels[i]) begin
				code = mkd_pkg::CODE_W'(i + 1);
			end
		end
	end

endmodule

@@ rtl/mkd_core.sv @@
// Debounce state: sample history, settle counter, stable key and press event.
`timescale 1ns / 1ps
module mkd_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  mkd_pkg::item_t              item,
	input  logic [mkd_pkg::COUNT_W-1:0] settle_ticks,
	output logic [mkd_pkg::CODE_W-1:0]  event_key,
	output logic [mkd_pkg::CODE_W-1:0]  stable_key
);

	logic [mkd_pkg::CODE_W-1:0]  pending_q, pending_d;
	logic [mkd_pkg::CODE_W-1:0]  debounced_q, debounced_d;
	logic [mkd_pkg::CODE_W-1:0]  previous_q, previous_d;
	logic [mkd_pkg::COUNT_W-1:0] count_q, count_d;

	// Next state of the debouncer for the item now leaving the input register.
	always_comb begin
		pending_d   = pending_q;
		debounced_d = debounced_q;
		previous_d  = previous_q;
		count_d     = count_q;
		event_key   = '0;
		if (item.func == mkd_pkg::FUNC_READ) begin
			event_key = pending_q;
			pending_d = '0;
		end else if (item.raw == previous_q) begin
			if (count_q < settle_ticks) begin
				count_d = count_q + mkd_pkg::COUNT_W'(1);
			end
			if (count_d >= settle_ticks && item.raw != debounced_q) begin
				if (item.raw != '0) begin
					pending_d = item.raw;
				end
				debounced_d = item.raw;
			end
		end else begin
			count_d    = '0;
			previous_d = item.raw;
		end
		stable_key = debounced_d;
	end

	// State is committed only when the item moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			debounced_q <= '0;
			previous_q  <= '0;
			count_q     <= '0;
		end else if (advance && item.valid) begin
			pending_q   <= pending_d;
			debounced_q <= debounced_d;
			previous_q  <= previous_d;
			count_q     <= count_d;
		end
	end

endmodule

@@ test/mkd_checker.sv @@
// Scoreboard for the matrix keypad debounce block: predicts each result and compares it.
`timescale 1ns / 1ps
module mkd_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        func,
	input  logic [mkd_pkg::LEVEL_W-1:0] row_levels,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [mkd_pkg::CODE_W-1:0]  event_key,
	input  logic [mkd_pkg::CODE_W-1:0]  stable_key,
	input  logic [mkd_pkg::CODE_W-1:0]  raw_code,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [mkd_pkg::COUNT_W-1:0] cfg_data,
	output int                          errors,
	output int                          pending
);

	typedef struct packed {
		logic [mkd_pkg::CODE_W-1:0] event_key;
		logic [mkd_pkg::CODE_W-1:0] stable_key;
		logic [mkd_pkg::CODE_W-1:0] raw_code;
	} key_report_t;

	// Predicted debounce state and the settle tick register.
	logic [mkd_pkg::COUNT_W-1:0] settle_cfg;
	logic [mkd_pkg::CODE_W-1:0]  latched_press;
	logic [mkd_pkg::CODE_W-1:0]  held_key;
	logic [mkd_pkg::CODE_W-1:0]  last_sample;
	logic [mkd_pkg::COUNT_W-1:0] match_count;

	key_report_t expected_reports[$];
	key_report_t seen;
	key_report_t want;
	int          fail_count;

	// Key code of one scan: first column with a row high, lowest row within it.
	function automatic logic [mkd_pkg::CODE_W-1:0] scan_code(
			input logic [mkd_pkg::LEVEL_W-1:0] lv);
		int idx;
		for (int c = 0; c < mkd_pkg::COLUMNS; c++) begin
			for (int r = 0; r < mkd_pkg::ROWS; r++) begin
				idx = c * mkd_pkg::ROWS + r;
				if (idx < mkd_pkg::LEVEL_W && lv[idx]) begin
					return mkd_pkg::CODE_W'(idx + 1);
				end
			end
		end
		return '0;
	endfunction

	// Advances the predicted state by one item and returns the result it gives.
	function automatic key_report_t predict_report(input mkd_pkg::func_t f,
			input logic [mkd_pkg::LEVEL_W-1:0] lv);
		key_report_t r;
		r = '0;
		if (f == mkd_pkg::FUNC_READ) begin
			r.event_key   = latched_press;
			latched_press = '0;
		end else begin
			r.raw_code = scan_code(lv);
			if (r.raw_code == last_sample) begin
				if (match_count < settle_cfg) begin
					match_count = match_count + mkd_pkg::COUNT_W'(1);
				end
				if (match_count >= settle_cfg && r.raw_code != held_key) begin
					if (r.raw_code != '0) begin
						latched_press = r.raw_code;
					end
					held_key = r.raw_code;
				end
			end else begin
				match_count = '0;
				last_sample = r.raw_code;
			end
		end
		r.stable_key = held_key;
		return r;
	endfunction

	task automatic note_mismatch(input string field,
			input logic [mkd_pkg::CODE_W-1:0] exp_v,
			input logic [mkd_pkg::CODE_W-1:0] act_v);
		fail_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
	endtask

	// Register writes, input transfers and output transfers, all seen at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_cfg    = mkd_pkg::SETTLE_RESET;
			latched_press = '0;
			held_key      = '0;
			last_sample   = '0;
			match_count   = '0;
			fail_count    = 0;
			expected_reports.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				settle_cfg = cfg_data;
			end
			if (in_valid && !in_stall) begin
				expected_reports.push_back(
					predict_report(mkd_pkg::func_t'(func), row_levels));
			end
			if (out_valid && !out_stall) begin
				seen = '{event_key, stable_key, raw_code};
				if (expected_reports.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
						$time, seen.event_key, seen.stable_key, seen.raw_code);
				end else begin
					want = expected_reports.pop_front();
					if (want.event_key !== seen.event_key) begin
						note_mismatch("event_key", want.event_key, seen.event_key);
					end
					if (want.stable_key !== seen.stable_key) begin
						note_mismatch("stable_key", want.stable_key, seen.stable_key);
					end
					if (want.raw_code !== seen.raw_code) begin
						note_mismatch("raw_code", want.raw_code, seen.raw_code);
					end
				end
			end
			pending <= expected_reports.size();
			errors  <= fail_count;
		end
	end

endmodule

@@ test/tb_matrix_keypad_debounce.sv @@
// Stimulus and verdict for the matrix keypad debounce block.
`timescale 1ns / 1ps
module tb_matrix_keypad_debounce;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic                        func;
	logic [mkd_pkg::LEVEL_W-1:0] row_levels;
	logic                        out_valid;
	logic                        out_stall;
	logic [mkd_pkg::CODE_W-1:0]  event_key;
	logic [mkd_pkg::CODE_W-1:0]  stable_key;
	logic [mkd_pkg::CODE_W-1:0]  raw_code;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [mkd_pkg::COUNT_W-1:0] cfg_data;
	int                          errors;
	int                          pending;

	// Random gaps on both sides; cleared for one stretch of the run.
	logic gaps_on = 1'b1;
	int   settle_now = mkd_pkg::SETTLE_RESET;
	int   items_sent = 0;

	matrix_keypad_debounce i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.row_levels (row_levels),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_key  (event_key),
		.stable_key (stable_key),
		.raw_code   (raw_code),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	mkd_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.row_levels (row_levels),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_key  (event_key),
		.stable_key (stable_key),
		.raw_code   (raw_code),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.pending    (pending)
	);

	// 4 ns clock.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Receiver stalls at random while gaps are enabled.
	always @(negedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < 34);
	end

	// Safety net against a hung handshake.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// One input transfer, with random idle cycles in front of it.
	task automatic put_item(input mkd_pkg::func_t f, input logic [mkd_pkg::LEVEL_W-1:0] lv);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		row_levels <= lv;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic scan(input logic [mkd_pkg::LEVEL_W-1:0] lv);
		put_item(mkd_pkg::FUNC_SCAN, lv);
	endtask

	task automatic read_event();
		put_item(mkd_pkg::FUNC_READ, mkd_pkg::LEVEL_W'($urandom));
	endtask

	// Holds the input low and waits until every outstanding result has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_settle(input int value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= mkd_pkg::COUNT_W'(value);
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_valid  <= 1'b0;
		settle_now = value;
	endtask

	// Scans of one level word, with the odd event read mixed in.
	task automatic hold_levels(input logic [mkd_pkg::LEVEL_W-1:0] lv, input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 12) begin
				read_event();
			end else begin
				scan(lv);
			end
		end
	endtask

	// Level word drawn so that every key code and every bit turns up.
	function automatic logic [mkd_pkg::LEVEL_W-1:0] pick_levels();
		int k;
		k = $urandom_range(mkd_pkg::LEVEL_W - 1);
		case ($urandom_range(4))
			0: begin
				return '0;
			end
			1: begin
				return mkd_pkg::LEVEL_W'(1) << k;
			end
			2: begin
				return mkd_pkg::LEVEL_W'($urandom);
			end
			3: begin
				return mkd_pkg::LEVEL_W'($urandom & $urandom & $urandom);
			end
			default: begin
				return (mkd_pkg::LEVEL_W'($urandom) << k) | (mkd_pkg::LEVEL_W'(1) << k);
			end
		endcase
	endfunction

	// Key presses of random length with contact bounce in front, until the count is reached.
	task automatic random_presses(input int count);
		int stop_at;
		int reach;
		stop_at = items_sent + count;
		reach   = (settle_now < 12) ? settle_now : 12;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 25) begin
				repeat ($urandom_range(1, 3)) scan(pick_levels());
			end
			hold_levels(pick_levels(), $urandom_range(1, reach + 3));
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		func       = mkd_pkg::FUNC_SCAN;
		row_levels = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Reset settle count: empty read, extreme level words, a full press and release.
		read_event();
		scan(16'h0000);
		scan(16'hFFFF);
		repeat (6) scan(16'h8000);
		read_event();
		read_event();
		repeat (6) scan(16'h0000);
		scan(16'hF000);
		scan(16'h0010);
		scan(16'h0100);
		scan(16'h0002);

		// Zero settle ticks: the second equal sample already updates the stable key.
		write_settle(0);
		repeat (2) scan(16'h0400);
		read_event();
		repeat (2) scan(16'h0000);

		// Lowered settle ticks: a count built up under the maximum still passes.
		write_settle(255);
		repeat (20) scan(16'h0020);
		write_settle(3);
		scan(16'h0020);
		read_event();

		// Maximum settle ticks with presses long enough to get through.
		write_settle(255);
		repeat (258) scan(16'h4000);
		read_event();
		repeat (258) scan(16'h0000);
		random_presses(60);

		write_settle(1);
		random_presses(180);
		write_settle(2);
		random_presses(90);
		drain_results();
		random_presses(90);
		write_settle(0);
		random_presses(170);
		write_settle(4);
		random_presses(170);
		write_settle($urandom_range(1, 10));
		random_presses(170);

		// A stretch with no gaps on either side.
		write_settle(5);
		gaps_on = 1'b0;
		random_presses(200);
		drain_results();
		gaps_on = 1'b1;

		write_settle(3);
		random_presses(170);

		drain_results();
		repeat (8) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
